// ===== design/rsfft_pkg.sv =====
// ----------------------------------------------------------------------------
// rsfft_pkg: shared types, codes and twiddle math
// Codes for the request channel and registers, the butterfly control bundle,
// store saturation and the fixed-point twiddle evaluation used to build the ROM.
// ----------------------------------------------------------------------------
package rsfft_pkg;

   localparam int STORE_BITS = 27;
   localparam int OP_BITS    = STORE_BITS + 3;
   localparam int RSP_DATA_W = 56;

   localparam logic signed [63:0] STORE_MAX = 64'sd67108863;
   localparam logic signed [63:0] STORE_MIN = -64'sd67108864;

   localparam logic [63:0] HALF_PI_Q62 = 64'h6487_ED51_10B4_611A;
   localparam logic [63:0] Q62_ONE     = 64'h4000_0000_0000_0000;

   // request modes
   localparam logic [1:0] MODE_WRITE = 2'd0;
   localparam logic [1:0] MODE_START = 2'd1;
   localparam logic [1:0] MODE_READ  = 2'd2;

   // result kinds
   localparam logic KIND_READ = 1'b0;
   localparam logic KIND_DONE = 1'b1;

   // register indexes
   localparam logic REG_LOG2_LENGTH = 1'b0;
   localparam logic REG_INVERSE     = 1'b1;

   // pass kinds
   localparam logic [1:0] PASS_R4  = 2'd0;
   localparam logic [1:0] PASS_R2  = 2'd1;
   localparam logic [1:0] PASS_CPY = 2'd2;

   typedef struct packed {
      logic       cap_en;
      logic [1:0] cap_sel;
      logic       tw_en;
      logic [1:0] tw_sel;
      logic       load_en;
      logic [1:0] out_sel;
      logic [1:0] pass;
      logic       inverse;
   } bfly_ctl_type;

   function automatic logic [STORE_BITS-1:0] sat_store(input logic signed [63:0] v);
      logic [STORE_BITS-1:0] r;
      if (v > STORE_MAX) r = STORE_MAX[STORE_BITS-1:0];
      else if (v < STORE_MIN) r = STORE_MIN[STORE_BITS-1:0];
      else r = v[STORE_BITS-1:0];
      return r;
   endfunction

   function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = 128'(a) * 128'(b);
      return p[125:62];
   endfunction

   // cos and sin of 2*pi*ph/2^32 scaled by 2^frac, returned as {cos, sin}
   function automatic logic [127:0] twiddle_calc(input logic [31:0] ph, input int frac);
      logic [1:0]        quad;
      logic [31:0]       r;
      logic              swap;
      logic [127:0]      prod;
      logic [63:0]       x, x2, t, s, c;
      logic signed [63:0] cv, sv, tmp, cw, sw;
      int                k;
      quad = ph[31:30];
      r    = {2'b00, ph[29:0]};
      swap = r > 32'h2000_0000;
      if (swap) r = 32'h4000_0000 - r;
      prod = 128'(HALF_PI_Q62) * 128'(64'(r) << 34);
      x  = prod[127:64];
      x2 = mul_q62(x, x);
      s  = x;
      t  = x;
      for (k = 1; k <= 12; k++) begin
         t = mul_q62(t, x2) / 64'((2 * k) * (2 * k + 1));
         if (k % 2 == 1) s = s - t;
         else s = s + t;
      end
      c = Q62_ONE;
      t = Q62_ONE;
      for (k = 1; k <= 12; k++) begin
         t = mul_q62(t, x2) / 64'((2 * k - 1) * (2 * k));
         if (k % 2 == 1) c = c - t;
         else c = c + t;
      end
      cv = signed'((c + (64'd1 << (61 - frac))) >> (62 - frac));
      sv = signed'((s + (64'd1 << (61 - frac))) >> (62 - frac));
      if (swap) begin
         tmp = cv;
         cv  = sv;
         sv  = tmp;
      end
      case (quad)
         2'd0: begin cw = cv;  sw = sv;  end
         2'd1: begin cw = -sv; sw = cv;  end
         2'd2: begin cw = -cv; sw = -sv; end
         default: begin cw = sv; sw = -cv; end
      endcase
      return {cw, sw};
   endfunction

endpackage

// ===== design/rsfft_store.sv =====
// ----------------------------------------------------------------------------
// rsfft_store: single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds between reads.
// ----------------------------------------------------------------------------
module rsfft_store #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 54
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/rsfft_twiddle_rom.sv =====
// ----------------------------------------------------------------------------
// rsfft_twiddle_rom: twiddle table
// Entry k holds cos and sin of 2*pi*k/MAX_POINTS in Q1.(TWIDDLE_BITS-1),
// one guard bit wide so that +1.0 is exact. Registered read.
// ----------------------------------------------------------------------------
module rsfft_twiddle_rom #(
   parameter int MAX_POINTS   = 1024,
   parameter int TWIDDLE_BITS = 18
) (
   input  logic                          clock,
   input  logic [$clog2(MAX_POINTS)-1:0] addr,
   output logic [2*TWIDDLE_BITS+1:0]     data
);

   localparam int TW_W  = TWIDDLE_BITS + 1;
   localparam int L2MAX = $clog2(MAX_POINTS);

   typedef logic [2*TW_W-1:0] rom_word_type;
   typedef rom_word_type rom_array_type [MAX_POINTS];

   function automatic rom_array_type build_rom();
      rom_array_type rom;
      logic [127:0]  pair;
      for (int k = 0; k < MAX_POINTS; k++) begin
         pair   = rsfft_pkg::twiddle_calc(32'(k) << (32 - L2MAX), TWIDDLE_BITS - 1);
         rom[k] = {pair[64 +: TW_W], pair[0 +: TW_W]};
      end
      return rom;
   endfunction

   localparam rom_array_type ROM = build_rom();

   logic [2*TW_W-1:0] data_ff;

   always_ff @(posedge clock) begin
      data_ff <= ROM[addr];
   end

   assign data = data_ff;

endmodule

// ===== design/rsfft_bfly.sv =====
// ----------------------------------------------------------------------------
// rsfft_bfly: shared butterfly arithmetic
// Holds the fetched points and twiddles, forms one butterfly output operand at
// a time, rotates it with one complex multiply, then rounds and saturates.
// ----------------------------------------------------------------------------
module rsfft_bfly #(
   parameter int TWIDDLE_BITS = 18
) (
   input  logic                          clock,
   input  rsfft_pkg::bfly_ctl_type       ctl,
   input  logic [2*rsfft_pkg::STORE_BITS-1:0] src_data,
   input  logic [2*TWIDDLE_BITS+1:0]     tw_data,
   output logic [2*rsfft_pkg::STORE_BITS-1:0] result
);

   localparam int SB   = rsfft_pkg::STORE_BITS;
   localparam int OPW  = rsfft_pkg::OP_BITS;
   localparam int TW_W = TWIDDLE_BITS + 1;
   localparam int FRAC = TWIDDLE_BITS - 1;
   localparam int PW   = OPW + TW_W;
   localparam int SW   = PW + 2;

   logic signed [SB-1:0]   pt_re_ff [4];
   logic signed [SB-1:0]   pt_im_ff [4];
   logic signed [TW_W-1:0] tw_c_ff [4];
   logic signed [TW_W-1:0] tw_s_ff [4];
   logic signed [OPW-1:0]  op_re_ff, op_im_ff, op_re_in, op_im_in;
   logic signed [TW_W-1:0] w_c_ff, w_s_ff, w_c_in, w_s_in;
   logic signed [PW-1:0]   p_rc_ff, p_is_ff, p_rs_ff, p_ic_ff;

   logic signed [OPW-1:0] apc_r, apc_i, amc_r, amc_i, bpd_r, bpd_i, bmd_r, bmd_i, jr, ji;
   logic signed [SW-1:0]  re_sum, im_sum, re_shift, im_shift;

   always_ff @(posedge clock) begin
      if (ctl.cap_en) begin
         pt_re_ff[ctl.cap_sel] <= src_data[SB-1:0];
         pt_im_ff[ctl.cap_sel] <= src_data[2*SB-1:SB];
      end
      if (ctl.tw_en) begin
         tw_c_ff[ctl.tw_sel] <= tw_data[2*TW_W-1:TW_W];
         tw_s_ff[ctl.tw_sel] <= tw_data[TW_W-1:0];
      end
      if (ctl.load_en) begin
         op_re_ff <= op_re_in;
         op_im_ff <= op_im_in;
         w_c_ff   <= w_c_in;
         w_s_ff   <= w_s_in;
      end
      p_rc_ff <= PW'(op_re_ff * w_c_ff);
      p_is_ff <= PW'(op_im_ff * w_s_ff);
      p_rs_ff <= PW'(op_re_ff * w_s_ff);
      p_ic_ff <= PW'(op_im_ff * w_c_ff);
   end

   always_comb begin
      apc_r = OPW'(pt_re_ff[0]) + OPW'(pt_re_ff[2]);
      apc_i = OPW'(pt_im_ff[0]) + OPW'(pt_im_ff[2]);
      amc_r = OPW'(pt_re_ff[0]) - OPW'(pt_re_ff[2]);
      amc_i = OPW'(pt_im_ff[0]) - OPW'(pt_im_ff[2]);
      bpd_r = OPW'(pt_re_ff[1]) + OPW'(pt_re_ff[3]);
      bpd_i = OPW'(pt_im_ff[1]) + OPW'(pt_im_ff[3]);
      bmd_r = OPW'(pt_re_ff[1]) - OPW'(pt_re_ff[3]);
      bmd_i = OPW'(pt_im_ff[1]) - OPW'(pt_im_ff[3]);
      // multiply by +i (forward) or -i (inverse)
      jr = ctl.inverse ? bmd_i : -bmd_i;
      ji = ctl.inverse ? -bmd_r : bmd_r;

      op_re_in = '0;
      op_im_in = '0;
      case (ctl.pass)
         rsfft_pkg::PASS_R4: begin
            case (ctl.out_sel)
               2'd0: begin op_re_in = apc_r + bpd_r; op_im_in = apc_i + bpd_i; end
               2'd1: begin op_re_in = amc_r - jr;    op_im_in = amc_i - ji;    end
               2'd2: begin op_re_in = apc_r - bpd_r; op_im_in = apc_i - bpd_i; end
               default: begin op_re_in = amc_r + jr; op_im_in = amc_i + ji;    end
            endcase
         end
         rsfft_pkg::PASS_R2: begin
            if (ctl.out_sel[0]) begin
               op_re_in = OPW'(pt_re_ff[0]) - OPW'(pt_re_ff[1]);
               op_im_in = OPW'(pt_im_ff[0]) - OPW'(pt_im_ff[1]);
            end else begin
               op_re_in = OPW'(pt_re_ff[0]) + OPW'(pt_re_ff[1]);
               op_im_in = OPW'(pt_im_ff[0]) + OPW'(pt_im_ff[1]);
            end
         end
         rsfft_pkg::PASS_CPY: begin
            op_re_in = OPW'(pt_re_ff[0]);
            op_im_in = OPW'(pt_im_ff[0]);
         end
         default: begin
            op_re_in = '0;
            op_im_in = '0;
         end
      endcase

      // unrotated outputs go through the multiplier at exactly 1.0
      if (ctl.pass == rsfft_pkg::PASS_R4 && ctl.out_sel != 2'd0) begin
         w_c_in = tw_c_ff[ctl.out_sel];
         w_s_in = ctl.inverse ? tw_s_ff[ctl.out_sel] : -tw_s_ff[ctl.out_sel];
      end else begin
         w_c_in = TW_W'(1) <<< FRAC;
         w_s_in = '0;
      end

      re_sum   = SW'(p_rc_ff) - SW'(p_is_ff) + (SW'(1) <<< (FRAC - 1));
      im_sum   = SW'(p_rs_ff) + SW'(p_ic_ff) + (SW'(1) <<< (FRAC - 1));
      re_shift = re_sum >>> FRAC;
      im_shift = im_sum >>> FRAC;
      result   = {rsfft_pkg::sat_store(64'(im_shift)), rsfft_pkg::sat_store(64'(re_shift))};
   end

endmodule

// ===== design/radix4_stockham_complex_fft.sv =====
// ----------------------------------------------------------------------------
// radix4_stockham_complex_fft: iterative radix-4 Stockham FFT engine
// Host writes and reads samples by index; a start runs the transform in place
// over the sample store using a work store and one shared butterfly unit.
//
//   channel  dir  tdata / tuser (low bit first)                  purpose
//   req      in   index, in_real, in_imag / mode                 access
//   rsp      out  out_real, out_imag / kind                      read data, done
//   csr      in   csr_index, csr_wdata                           log2_length, inverse
//
// A write lands in the store as it is accepted; read data follows in the next
// cycle through the output register. A start keeps the engine busy through
// its radix-4 passes, any radix-2 pass and any copy back, paced by the single
// read port of each store and the one complex multiplier. Reset is synchronous
// and clears control only; stores hold garbage until written. A stalled result
// blocks every request.
// ----------------------------------------------------------------------------
module radix4_stockham_complex_fft #(
   parameter int MAX_POINTS   = 1024,
   parameter int SAMPLE_BITS  = 16,
   parameter int TWIDDLE_BITS = 18
) (
   input  logic clock,
   input  logic reset,
   input  logic                                       req_tvalid,
   output logic                                       req_tready,
   // index[9:0], in_real, in_imag, zero fill
   input  logic [((10+2*SAMPLE_BITS+7)/8)*8-1:0]      req_tdata,
   // mode
   input  logic [1:0]                                 req_tuser,
   output logic                                       rsp_tvalid,
   input  logic                                       rsp_tready,
   // out_real[26:0], out_imag[53:27], zero fill
   output logic [rsfft_pkg::RSP_DATA_W-1:0]           rsp_tdata,
   // kind
   output logic                                       rsp_tuser,
   input  logic                                       csr_we,
   input  logic                                       csr_index,
   input  logic [3:0]                                 csr_wdata
);

   localparam int AW    = $clog2(MAX_POINTS);
   localparam int L2MAX = AW;
   localparam int SB    = rsfft_pkg::STORE_BITS;
   localparam int TW_W  = TWIDDLE_BITS + 1;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_FETCH = 3'd1;
   localparam logic [2:0] ST_LOAD  = 3'd2;
   localparam logic [2:0] ST_MUL   = 3'd3;
   localparam logic [2:0] ST_WRITE = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [2:0]    kcnt_ff, kcnt_in;
   logic [1:0]    jcnt_ff, jcnt_in;
   logic [AW-1:0] bf_ff, bf_in;
   logic [1:0]    pass_ff, pass_in;
   logic [4:0]    rem_ff, rem_in;
   logic [4:0]    sh_ff, sh_in;
   logic [4:0]    len_ff, len_in;
   logic          src_work_ff, src_work_in;
   logic [3:0]    log2_length_ff;
   logic          inverse_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_kind_ff, rsp_kind_in;

   logic                         req_acc;
   logic [1:0]                   mode;
   logic [AW-1:0]                host_addr;
   logic signed [SAMPLE_BITS-1:0] in_real, in_imag;
   logic [2*SB-1:0]              host_wdata;
   logic [4:0]                   len_sel;
   logic [2:0]                   nin_last;
   logic                         fetch_rd;
   logic [AW-1:0]                fetch_addr, out_addr, last_bf, qmask, p_idx, rom_addr;
   logic [2*SB-1:0]              sample_q, work_q, src_q, bfly_result;
   logic [2*TW_W-1:0]            tw_q;
   logic                         s_wr_en, s_rd_en, w_wr_en, w_rd_en;
   logic [AW-1:0]                s_wr_addr, s_rd_addr;
   logic [2*SB-1:0]              s_wr_data;
   logic [4:0]                   cnt_log, rem_next;
   rsfft_pkg::bfly_ctl_type      ctl;

   assign mode      = req_tuser;
   assign host_addr = AW'(req_tdata[9:0]);
   assign in_real   = req_tdata[10 +: SAMPLE_BITS];
   assign in_imag   = req_tdata[10+SAMPLE_BITS +: SAMPLE_BITS];
   assign host_wdata = {rsfft_pkg::sat_store(64'(in_imag)), rsfft_pkg::sat_store(64'(in_real))};

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_acc    = req_tvalid && req_tready;

   assign len_sel = (5'(log2_length_ff) > 5'(L2MAX)) ? 5'(L2MAX) : 5'(log2_length_ff);

   // pass geometry
   always_comb begin
      case (pass_ff)
         rsfft_pkg::PASS_R4: begin nin_last = 3'd3; cnt_log = len_ff - 5'd2; end
         rsfft_pkg::PASS_R2: begin nin_last = 3'd1; cnt_log = len_ff - 5'd1; end
         default:            begin nin_last = 3'd0; cnt_log = len_ff;        end
      endcase
      last_bf = AW'(((AW+1)'(1) << cnt_log) - (AW+1)'(1));
      qmask   = AW'(((AW+1)'(1) << sh_ff) - (AW+1)'(1));
      p_idx   = bf_ff >> sh_ff;
      // twiddle step follows the sub-transform length of the current pass
      rom_addr = AW'(p_idx * AW'(kcnt_ff[1:0])) << (5'(L2MAX) - rem_ff);

      case (pass_ff)
         rsfft_pkg::PASS_R4: begin
            fetch_addr = bf_ff | (AW'(kcnt_ff[1:0]) << (len_ff - 5'd2));
            out_addr   = (p_idx << (sh_ff + 5'd2)) | (AW'(jcnt_ff) << sh_ff) | (bf_ff & qmask);
         end
         rsfft_pkg::PASS_R2: begin
            fetch_addr = bf_ff | (AW'(kcnt_ff[0]) << (len_ff - 5'd1));
            out_addr   = bf_ff | (AW'(jcnt_ff[0]) << (len_ff - 5'd1));
         end
         default: begin
            fetch_addr = bf_ff;
            out_addr   = bf_ff;
         end
      endcase
   end

   assign fetch_rd = (state_ff == ST_FETCH) && (kcnt_ff <= nin_last);
   assign src_q    = src_work_ff ? work_q : sample_q;

   // store ports: host owns the sample store while idle
   assign s_wr_en   = (req_acc && mode == rsfft_pkg::MODE_WRITE) ||
                      (state_ff == ST_WRITE && src_work_ff);
   assign s_wr_addr = (state_ff == ST_IDLE) ? host_addr : out_addr;
   assign s_wr_data = (state_ff == ST_IDLE) ? host_wdata : bfly_result;
   assign s_rd_en   = (req_acc && mode == rsfft_pkg::MODE_READ) || (fetch_rd && !src_work_ff);
   assign s_rd_addr = (state_ff == ST_IDLE) ? host_addr : fetch_addr;
   assign w_wr_en   = (state_ff == ST_WRITE) && !src_work_ff;
   assign w_rd_en   = fetch_rd && src_work_ff;

   assign ctl.cap_en  = (state_ff == ST_FETCH) && (kcnt_ff != 3'd0);
   assign ctl.cap_sel = 2'(kcnt_ff - 3'd1);
   assign ctl.tw_en   = (state_ff == ST_FETCH) && (pass_ff == rsfft_pkg::PASS_R4) &&
                        (kcnt_ff >= 3'd2);
   assign ctl.tw_sel  = 2'(kcnt_ff - 3'd1);
   assign ctl.load_en = (state_ff == ST_LOAD);
   assign ctl.out_sel = jcnt_ff;
   assign ctl.pass    = pass_ff;
   assign ctl.inverse = inverse_ff;

   rsfft_store #(.DEPTH(MAX_POINTS), .WIDTH(2*SB)) u_sample_store (
      .clock   (clock),
      .wr_en   (s_wr_en),
      .wr_addr (s_wr_addr),
      .wr_data (s_wr_data),
      .rd_en   (s_rd_en),
      .rd_addr (s_rd_addr),
      .rd_data (sample_q)
   );

   rsfft_store #(.DEPTH(MAX_POINTS), .WIDTH(2*SB)) u_work_store (
      .clock   (clock),
      .wr_en   (w_wr_en),
      .wr_addr (out_addr),
      .wr_data (bfly_result),
      .rd_en   (w_rd_en),
      .rd_addr (fetch_addr),
      .rd_data (work_q)
   );

   rsfft_twiddle_rom #(.MAX_POINTS(MAX_POINTS), .TWIDDLE_BITS(TWIDDLE_BITS)) u_twiddle_rom (
      .clock (clock),
      .addr  (rom_addr),
      .data  (tw_q)
   );

   rsfft_bfly #(.TWIDDLE_BITS(TWIDDLE_BITS)) u_bfly (
      .clock    (clock),
      .ctl      (ctl),
      .src_data (src_q),
      .tw_data  (tw_q),
      .result   (bfly_result)
   );

   // sequencer
   always_comb begin
      state_in    = state_ff;
      kcnt_in     = kcnt_ff;
      jcnt_in     = jcnt_ff;
      bf_in       = bf_ff;
      pass_in     = pass_ff;
      rem_in      = rem_ff;
      sh_in       = sh_ff;
      len_in      = len_ff;
      src_work_in = src_work_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rem_next    = rem_ff - 5'd2;

      case (state_ff)
         ST_IDLE: begin
            if (req_acc && mode == rsfft_pkg::MODE_READ) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = rsfft_pkg::KIND_READ;
            end else if (req_acc && mode == rsfft_pkg::MODE_START) begin
               if (len_sel == 5'd0) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = rsfft_pkg::KIND_DONE;
               end else begin
                  state_in    = ST_FETCH;
                  pass_in     = (len_sel >= 5'd2) ? rsfft_pkg::PASS_R4 : rsfft_pkg::PASS_R2;
                  len_in      = len_sel;
                  rem_in      = len_sel;
                  sh_in       = '0;
                  src_work_in = 1'b0;
                  bf_in       = '0;
                  kcnt_in     = '0;
                  jcnt_in     = '0;
               end
            end
         end
         ST_FETCH: begin
            kcnt_in = kcnt_ff + 3'd1;
            if (kcnt_ff == nin_last + 3'd1) begin
               kcnt_in  = '0;
               jcnt_in  = '0;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: state_in = ST_MUL;
         ST_MUL:  state_in = ST_WRITE;
         ST_WRITE: begin
            if (3'(jcnt_ff) != nin_last) begin
               jcnt_in  = jcnt_ff + 2'd1;
               state_in = ST_LOAD;
            end else if (bf_ff != last_bf) begin
               bf_in    = bf_ff + AW'(1);
               state_in = ST_FETCH;
            end else begin
               // pass complete: pick the next one or finish
               bf_in       = '0;
               src_work_in = !src_work_ff;
               state_in    = ST_FETCH;
               case (pass_ff)
                  rsfft_pkg::PASS_R4: begin
                     rem_in = rem_next;
                     sh_in  = sh_ff + 5'd2;
                     if (rem_next >= 5'd2) pass_in = rsfft_pkg::PASS_R4;
                     else if (rem_next == 5'd1) pass_in = rsfft_pkg::PASS_R2;
                     else if (!src_work_ff) pass_in = rsfft_pkg::PASS_CPY;
                     else state_in = ST_IDLE;
                  end
                  rsfft_pkg::PASS_R2: begin
                     if (!src_work_ff) pass_in = rsfft_pkg::PASS_CPY;
                     else state_in = ST_IDLE;
                  end
                  default: state_in = ST_IDLE;
               endcase
               if (state_in == ST_IDLE) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = rsfft_pkg::KIND_DONE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         kcnt_ff        <= '0;
         jcnt_ff        <= '0;
         bf_ff          <= '0;
         pass_ff        <= rsfft_pkg::PASS_R4;
         rem_ff         <= '0;
         sh_ff          <= '0;
         len_ff         <= '0;
         src_work_ff    <= 1'b0;
         log2_length_ff <= 4'd10;
         inverse_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         rsp_kind_ff    <= rsfft_pkg::KIND_READ;
      end else begin
         state_ff     <= state_in;
         kcnt_ff      <= kcnt_in;
         jcnt_ff      <= jcnt_in;
         bf_ff        <= bf_in;
         pass_ff      <= pass_in;
         rem_ff       <= rem_in;
         sh_ff        <= sh_in;
         len_ff       <= len_in;
         src_work_ff  <= src_work_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_kind_ff  <= rsp_kind_in;
         if (csr_we && csr_index == rsfft_pkg::REG_LOG2_LENGTH) log2_length_ff <= csr_wdata;
         if (csr_we && csr_index == rsfft_pkg::REG_INVERSE) inverse_ff <= csr_wdata[0];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   // read data stays in the store's output register until the next read
   assign rsp_tdata  = (rsp_kind_ff == rsfft_pkg::KIND_DONE) ? '0 :
                       {2'b00, sample_q};

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for radix4_stockham_complex_fft
// Streams sample writes, transform starts and reads into the engine under
// random idle bursts on both sides. A local fixed-point FFT model predicts
// every read and done transaction, and the monitor compares them in order.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  POINTS   = 1024;
   localparam int  FRAC     = 17;
   localparam int  WD_LIMIT = 200000;

   typedef struct {
      logic [1:0]         mode;
      logic [9:0]         index;
      logic signed [15:0] re;
      logic signed [15:0] im;
   } access_type;

   typedef struct {
      logic               kind;
      logic signed [26:0] re;
      logic signed [26:0] im;
   } result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [rsfft_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_we = 1'b0;
   logic        csr_index = 1'b0;
   logic [3:0]  csr_wdata = '0;

   access_type pending[$];
   result_type fft_results[$];
   access_type cur_access;
   int      written[$];
   bit      idle_en = 1'b1;
   bit      req_taken;
   bit      next_valid;
   int      req_gap;
   int      rsp_gap;
   int      quiet_cycles;
   int      item_count;
   bit      failed;

   // engine model state
   longint  store_re[2][POINTS];
   longint  store_im[2][POINTS];
   int      cfg_log2 = 10;
   bit      cfg_inverse = 1'b0;

   radix4_stockham_complex_fft uut (.*);

   always #4 clock = ~clock;

   function automatic longint clip27(input longint v);
      if (v > 64'sd67108863) return 64'sd67108863;
      if (v < -64'sd67108864) return -64'sd67108864;
      return v;
   endfunction

   function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[125:62];
   endfunction

   // cos/sin of 2*pi*phase/2^32 in Q1.17, rounded to nearest
   task automatic rom_twiddle(input logic [31:0] phase, output longint wc, output longint ws);
      logic [31:0]  r;
      bit           swap;
      logic [127:0] prod;
      logic [63:0]  x, x2, t, sn, cs;
      longint       cv, sv, tmp;
      r = {2'b00, phase[29:0]};
      swap = r > 32'h2000_0000;
      if (swap) r = 32'h4000_0000 - r;
      prod = {64'd0, rsfft_pkg::HALF_PI_Q62} * {64'd0, 64'(r) << 34};
      x = prod[127:64];
      x2 = q62_mul(x, x);
      sn = x;
      t = x;
      for (int k = 1; k <= 12; k++) begin
         t = q62_mul(t, x2) / 64'((2 * k) * (2 * k + 1));
         sn = (k % 2 == 1) ? sn - t : sn + t;
      end
      cs = rsfft_pkg::Q62_ONE;
      t = rsfft_pkg::Q62_ONE;
      for (int k = 1; k <= 12; k++) begin
         t = q62_mul(t, x2) / 64'((2 * k - 1) * (2 * k));
         cs = (k % 2 == 1) ? cs - t : cs + t;
      end
      cv = longint'((cs + (64'd1 << 44)) >> 45);
      sv = longint'((sn + (64'd1 << 44)) >> 45);
      if (swap) begin
         tmp = cv;
         cv = sv;
         sv = tmp;
      end
      case (phase[31:30])
         2'd0: begin wc = cv;  ws = sv;  end
         2'd1: begin wc = -sv; ws = cv;  end
         2'd2: begin wc = -cv; ws = -sv; end
         default: begin wc = sv; ws = -cv; end
      endcase
   endtask

   function automatic longint round17(input longint v);
      return (v + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
   endfunction

   task automatic rotate_into(input longint ar, input longint ai, input longint wc,
                              input longint ws, input int dst, input int pos);
      store_re[dst][pos] = clip27(round17(ar * wc - ai * ws));
      store_im[dst][pos] = clip27(round17(ar * ws + ai * wc));
   endtask

   task automatic run_fft();
      int     m, s, n1, src, dst;
      longint wc[4], ws[4];
      longint a_r, a_i, b_r, b_i, c_r, c_i, d_r, d_i;
      longint apc_r, apc_i, amc_r, amc_i, bpd_r, bpd_i, bmd_r, bmd_i, jr, ji;
      logic [31:0] phase;
      m = (cfg_log2 > 10) ? 10 : cfg_log2;
      s = 1;
      src = 0;
      while (m >= 2) begin
         n1 = 1 << (m - 2);
         dst = 1 - src;
         for (int p = 0; p < n1; p++) begin
            for (int e = 1; e <= 3; e++) begin
               phase = 32'(longint'(e * p) << (32 - m));
               rom_twiddle(phase, wc[e], ws[e]);
               if (!cfg_inverse) ws[e] = -ws[e];
            end
            for (int q = 0; q < s; q++) begin
               a_r = store_re[src][q + s * p];        a_i = store_im[src][q + s * p];
               b_r = store_re[src][q + s * (p + n1)]; b_i = store_im[src][q + s * (p + n1)];
               c_r = store_re[src][q + s * (p + 2 * n1)];
               c_i = store_im[src][q + s * (p + 2 * n1)];
               d_r = store_re[src][q + s * (p + 3 * n1)];
               d_i = store_im[src][q + s * (p + 3 * n1)];
               apc_r = a_r + c_r; apc_i = a_i + c_i;
               amc_r = a_r - c_r; amc_i = a_i - c_i;
               bpd_r = b_r + d_r; bpd_i = b_i + d_i;
               bmd_r = b_r - d_r; bmd_i = b_i - d_i;
               jr = cfg_inverse ? bmd_i : -bmd_i;
               ji = cfg_inverse ? -bmd_r : bmd_r;
               store_re[dst][q + s * 4 * p] = clip27(apc_r + bpd_r);
               store_im[dst][q + s * 4 * p] = clip27(apc_i + bpd_i);
               rotate_into(amc_r - jr, amc_i - ji, wc[1], ws[1], dst, q + s * (4 * p + 1));
               rotate_into(apc_r - bpd_r, apc_i - bpd_i, wc[2], ws[2], dst,
                           q + s * (4 * p + 2));
               rotate_into(amc_r + jr, amc_i + ji, wc[3], ws[3], dst, q + s * (4 * p + 3));
            end
         end
         m -= 2;
         s <<= 2;
         src = dst;
      end
      if (m == 1) begin
         dst = 1 - src;
         for (int q = 0; q < s; q++) begin
            a_r = store_re[src][q];     a_i = store_im[src][q];
            b_r = store_re[src][q + s]; b_i = store_im[src][q + s];
            store_re[dst][q] = clip27(a_r + b_r);
            store_im[dst][q] = clip27(a_i + b_i);
            store_re[dst][q + s] = clip27(a_r - b_r);
            store_im[dst][q + s] = clip27(a_i - b_i);
         end
         s <<= 1;
         src = dst;
      end
      if (src != 0) begin
         for (int i = 0; i < s; i++) begin
            store_re[0][i] = store_re[src][i];
            store_im[0][i] = store_im[src][i];
         end
      end
   endtask

   task automatic predict_access(input access_type a);
      result_type r;
      case (a.mode)
         rsfft_pkg::MODE_WRITE: begin
            store_re[0][a.index] = a.re;
            store_im[0][a.index] = a.im;
         end
         rsfft_pkg::MODE_START: begin
            run_fft();
            r.kind = rsfft_pkg::KIND_DONE;
            r.re = '0;
            r.im = '0;
            fft_results.push_back(r);
         end
         rsfft_pkg::MODE_READ: begin
            r.kind = rsfft_pkg::KIND_READ;
            r.re = 27'(store_re[0][a.index]);
            r.im = 27'(store_im[0][a.index]);
            fft_results.push_back(r);
         end
         default: ;
      endcase
   endtask

   // sample acceptances and results at the rising edge
   always @(posedge clock) begin
      req_taken = req_tvalid && req_tready;
      if (!reset) begin
         if (req_taken) predict_access(cur_access);
         if (rsp_tvalid && rsp_tready) begin
            if (fft_results.size() == 0) begin
               $error("unexpected result transaction kind=%0d", rsp_tuser);
               failed = 1'b1;
            end else begin
               result_type want;
               want = fft_results.pop_front();
               if (rsp_tuser !== want.kind) begin
                  $error("kind expected %0d actual %0d", want.kind, rsp_tuser);
                  failed = 1'b1;
               end
               if (rsp_tdata[26:0] !== want.re) begin
                  $error("out_real expected %0d actual %0d", want.re,
                         $signed(rsp_tdata[26:0]));
                  failed = 1'b1;
               end
               if (rsp_tdata[53:27] !== want.im) begin
                  $error("out_imag expected %0d actual %0d", want.im,
                         $signed(rsp_tdata[53:27]));
                  failed = 1'b1;
               end
            end
         end
         quiet_cycles = (req_taken || (rsp_tvalid && rsp_tready)) ? 0 : quiet_cycles + 1;
      end
   end

   always @(posedge clock) begin
      if (quiet_cycles >= WD_LIMIT) begin
         $display("FAIL radix4_stockham_complex_fft");
         $finish;
      end
   end

   // request driver: hold until accepted, then advance or idle
   always @(negedge clock) begin
      if (!reset && (!req_tvalid || req_taken)) begin
         next_valid = 1'b0;
         if (req_gap > 0) begin
            req_gap--;
         end else if (pending.size() > 0) begin
            cur_access = pending.pop_front();
            next_valid = 1'b1;
            if (idle_en && $urandom_range(0, 9) == 0) req_gap = $urandom_range(1, 18);
         end
         req_tvalid <= next_valid;
         req_tdata <= {6'd0, cur_access.im, cur_access.re, cur_access.index};
         req_tuser <= cur_access.mode;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (idle_en && $urandom_range(0, 11) == 0) rsp_gap = $urandom_range(1, 18);
      end
   end

   task automatic add_access(input logic [1:0] mode, input int index,
                             input logic signed [15:0] re, input logic signed [15:0] im);
      access_type a;
      a.mode = mode;
      a.index = 10'(index);
      a.re = re;
      a.im = im;
      pending.push_back(a);
      if (mode != 2'd3) item_count++;
      if (mode == rsfft_pkg::MODE_WRITE) written.push_back(index);
   endtask

   function automatic logic signed [15:0] pick_sample();
      case ($urandom_range(0, 11))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return 16'sd0;
         3: return -16'sd1;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic drain();
      wait (pending.size() == 0 && !req_tvalid && fft_results.size() == 0);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input int value);
      drain();
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= 4'(value);
      if (idx == rsfft_pkg::REG_LOG2_LENGTH) cfg_log2 = value;
      else cfg_inverse = value[0];
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      int lg, npts, sel;
      bit first_phase;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, every mode, unused mode, length one
      write_csr(rsfft_pkg::REG_LOG2_LENGTH, 2);
      write_csr(rsfft_pkg::REG_INVERSE, 0);
      add_access(rsfft_pkg::MODE_WRITE, 0, 16'sh7FFF, 16'sh8000);
      add_access(rsfft_pkg::MODE_WRITE, 1, 16'sh8000, 16'sh7FFF);
      add_access(rsfft_pkg::MODE_WRITE, 2, 16'sd0, -16'sd1);
      add_access(rsfft_pkg::MODE_WRITE, 3, -16'sd1, 16'sd0);
      add_access(rsfft_pkg::MODE_WRITE, 1023, 16'sh7FFF, 16'sh7FFF);
      add_access(2'd3, 1023, 16'sh8000, 16'sh8000);
      add_access(rsfft_pkg::MODE_READ, 1023, 0, 0);
      add_access(rsfft_pkg::MODE_READ, 0, 0, 0);
      add_access(rsfft_pkg::MODE_START, 0, 0, 0);
      for (int i = 0; i < 4; i++) add_access(rsfft_pkg::MODE_READ, i, 0, 0);
      write_csr(rsfft_pkg::REG_INVERSE, 1);
      add_access(rsfft_pkg::MODE_START, 0, 0, 0);
      add_access(rsfft_pkg::MODE_READ, 2, 0, 0);
      write_csr(rsfft_pkg::REG_LOG2_LENGTH, 0);
      add_access(rsfft_pkg::MODE_START, 0, 0, 0);
      add_access(rsfft_pkg::MODE_READ, 0, 0, 0);

      first_phase = 1'b1;
      while (item_count < 1600) begin
         sel = $urandom_range(0, 19);
         if (sel < 14) lg = $urandom_range(0, 6);
         else if (sel < 18) lg = $urandom_range(7, 9);
         else if (sel == 18) lg = 10;
         else lg = $urandom_range(11, 15);
         npts = 1 << ((lg > 10) ? 10 : lg);
         // keep the total near the planned item count
         if (item_count + npts > 1560) begin
            lg = $urandom_range(0, 4);
            npts = 1 << lg;
         end
         write_csr(rsfft_pkg::REG_LOG2_LENGTH, lg);
         write_csr(rsfft_pkg::REG_INVERSE, $urandom_range(0, 1));
         if (item_count > 1400) idle_en = 1'b0;
         for (int i = 0; i < npts; i++) begin
            add_access(rsfft_pkg::MODE_WRITE, i, pick_sample(), pick_sample());
            sel = $urandom_range(0, 29);
            if (sel == 0) begin
               add_access(2'd3, $urandom_range(0, 1023), 16'($urandom), 16'($urandom));
            end else if (sel == 1) begin
               add_access(rsfft_pkg::MODE_READ,
                          written[$urandom_range(0, written.size() - 1)], 0, 0);
            end else if (sel == 2) begin
               add_access(rsfft_pkg::MODE_WRITE, $urandom_range(0, 1023),
                          pick_sample(), pick_sample());
            end
         end
         if (first_phase || $urandom_range(0, 5) == 0) drain();
         first_phase = 1'b0;
         // repeated starts let the growth run into saturation
         sel = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 4) : 1;
         for (int k = 0; k < sel; k++) begin
            add_access(rsfft_pkg::MODE_START, $urandom_range(0, 1023),
                       16'($urandom), 16'($urandom));
            for (int j = 0; j < 6; j++)
               add_access(rsfft_pkg::MODE_READ,
                          written[$urandom_range(0, written.size() - 1)], 0, 0);
         end
      end
      drain();
      repeat (20) @(posedge clock);
      if (!failed) begin
         $display("PASS radix4_stockham_complex_fft");
      end else begin
         $display("FAIL radix4_stockham_complex_fft");
      end
      $finish;
   end

endmodule

// ===== files.f =====
design/rsfft_pkg.sv
design/rsfft_store.sv
design/rsfft_twiddle_rom.sv
design/rsfft_bfly.sv
design/radix4_stockham_complex_fft.sv
test/tb.sv
